// File: design/saq_pkg.sv
`default_nettype none
package saq_pkg;
    localparam int unsigned TIME_W   = 62;
    localparam int unsigned FIRE_W   = 63;
    localparam int unsigned RELOAD_W = 31;
    localparam int unsigned STATUS_W = 3;

    typedef enum logic [1:0] {
        REQ_ARM_REL = 2'd0,
        REQ_ARM_ABS = 2'd1,
        REQ_CANCEL  = 2'd2,
        REQ_EVENT   = 2'd3
    } t_req;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_ARMED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EARLY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd4;

    localparam logic [RELOAD_W-1:0] MAX_RELOAD = {RELOAD_W{1'b1}};
endpackage
`default_nettype wire

// File: design/saq_ram.sv
`default_nettype none
module saq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: design/sorted_alarm_queue_top.sv
`default_nettype none
// Sorted alarm queue: alarm slots held in a doubly linked list ordered by fire time.
// A request first goes through decode; a cancel of an armed slot or a rearm then unlinks
// the slot, an arm walks the list (one RAM read per slot walked) and links the slot in,
// and an event fires or rechecks the head. One request at a time: busy stays high until
// the result cycle, in which start may transfer again. Reset (synchronous, active low)
// empties the queue.
module sorted_alarm_queue_top #(
    parameter int ALARM_SLOTS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic [3:0]                     i_alarm_id,
    input  wire logic [saq_pkg::TIME_W-1:0]     i_time_value,
    input  wire logic [saq_pkg::TIME_W-1:0]     i_now,
    output logic                                o_valid,
    output logic [saq_pkg::STATUS_W-1:0]        o_status,
    output logic                                o_fired,
    output logic [3:0]                          o_fired_id,
    output logic                                o_timer_load,
    output logic [saq_pkg::RELOAD_W-1:0]        o_timer_value
);
    localparam int IW = $clog2(ALARM_SLOTS);
    localparam int LW = IW + 1;
    localparam int FW = saq_pkg::FIRE_W;
    localparam int TW = saq_pkg::TIME_W;
    localparam int RW = saq_pkg::RELOAD_W;
    localparam int EW = FW + 2 * LW;
    localparam logic [LW-1:0] NIL = LW'(ALARM_SLOTS);

    // RAM entry layout: {fire, next, prev}
    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_UNL_SELF, S_UNL_NX, S_UNL_PV, S_UNL_END, S_INS_INIT, S_WALK,
        S_INS_CUR, S_INS_PV, S_INS_TAIL, S_INS_TAILN, S_INS_END, S_RELOAD, S_EVT_HEAD,
        S_EVT_NX, S_DONE
    } t_state;

    t_state                       r_state;
    saq_pkg::t_req                r_req;
    logic [3:0]                   r_id;
    logic [FW-1:0]                r_fire;
    logic [TW-1:0]                r_now;
    logic [LW-1:0]                r_head, r_tail, r_cur, r_pv, r_nx;
    logic [ALARM_SLOTS-1:0]       r_armed;
    logic                         r_moved;
    logic [saq_pkg::STATUS_W-1:0] r_status;
    logic                         r_fired;
    logic [3:0]                   r_fired_id;
    logic                         r_load;
    logic [RW-1:0]                r_value;
    logic [EW-1:LW]               r_ent;   // fire and next of the slot the walk stopped at

    logic                         ram_we;
    logic [IW-1:0]                ram_waddr, ram_raddr;
    logic [EW-1:0]                ram_wdata, ram_rdata;

    saq_ram #(.WIDTH(EW), .DEPTH(ALARM_SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    wire [FW-1:0] rd_fire = ram_rdata[EW-1 -: FW];
    wire [LW-1:0] rd_next = ram_rdata[2*LW-1 -: LW];
    wire [LW-1:0] rd_prev = ram_rdata[LW-1:0];
    wire          id_ok   = ({28'd0, r_id} < 32'(ALARM_SLOTS));
    wire [IW-1:0] id_ix   = IW'(r_id);
    wire [LW-1:0] s_link  = LW'(r_id);

    assign busy = (r_state != S_IDLE);

    // Reload for the entry on the read port: fire minus now, clamped to 0 and INT_MAX.
    logic [FW-1:0] fire_gap;
    logic [RW-1:0] reload_val;
    always_comb begin
        fire_gap = rd_fire - FW'(r_now);
        if (rd_fire < FW'(r_now)) begin
            reload_val = '0;
        end else if (|fire_gap[FW-1:RW]) begin
            reload_val = saq_pkg::MAX_RELOAD;
        end else begin
            reload_val = fire_gap[RW-1:0];
        end
    end

    // RAM port control. A read issued in one state returns its entry in the next; each
    // link patch rewrites a whole entry from that returned word, or from the entry held by
    // the walk. No state reads the entry it writes, so no forwarding is needed.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = id_ix;
        ram_wdata = {r_fire, NIL, r_tail};
        ram_raddr = id_ix;
        unique case (r_state)
            S_DECODE: begin
                // event: fetch the head; arm and cancel: fetch the own slot
                ram_raddr = (r_req == saq_pkg::REQ_EVENT) ? r_head[IW-1:0] : id_ix;
            end
            S_UNL_SELF: begin
                ram_raddr = (rd_next != NIL) ? rd_next[IW-1:0] : rd_prev[IW-1:0];
            end
            S_UNL_NX: begin
                // next neighbour takes over our prev link
                ram_we    = 1'b1;
                ram_waddr = r_nx[IW-1:0];
                ram_wdata = {rd_fire, rd_next, r_pv};
                ram_raddr = r_pv[IW-1:0];
            end
            S_UNL_PV: begin
                // previous neighbour takes over our next link
                ram_we    = 1'b1;
                ram_waddr = r_pv[IW-1:0];
                ram_wdata = {rd_fire, r_nx, rd_prev};
            end
            S_UNL_END, S_INS_INIT, S_INS_END: begin
                ram_raddr = r_head[IW-1:0];
            end
            S_WALK: begin
                ram_raddr = rd_next[IW-1:0];
                // first later fire time: write the new slot in front of it
                if (rd_fire > r_fire) begin
                    ram_we    = 1'b1;
                    ram_waddr = id_ix;
                    ram_wdata = {r_fire, r_cur, rd_prev};
                end
            end
            S_INS_CUR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur[IW-1:0];
                ram_wdata = {r_ent, s_link};
                ram_raddr = r_pv[IW-1:0];
            end
            S_INS_PV: begin
                ram_we    = 1'b1;
                ram_waddr = r_pv[IW-1:0];
                ram_wdata = {rd_fire, s_link, rd_prev};
            end
            S_INS_TAIL: begin
                // append after the tail
                ram_we    = 1'b1;
                ram_waddr = id_ix;
                ram_wdata = {r_fire, NIL, r_tail};
                ram_raddr = r_tail[IW-1:0];
            end
            S_INS_TAILN: begin
                ram_we    = 1'b1;
                ram_waddr = r_tail[IW-1:0];
                ram_wdata = {rd_fire, s_link, rd_prev};
            end
            S_EVT_HEAD: begin
                ram_raddr = rd_next[IW-1:0];
            end
            S_EVT_NX: begin
                // new head loses its prev link
                ram_we    = 1'b1;
                ram_waddr = r_nx[IW-1:0];
                ram_wdata = {rd_fire, rd_next, NIL};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_head        <= NIL;
            r_tail        <= NIL;
            r_armed       <= '0;
            o_valid       <= 1'b0;
            o_status      <= saq_pkg::ST_OK;
            o_fired       <= 1'b0;
            o_fired_id    <= '0;
            o_timer_load  <= 1'b0;
            o_timer_value <= '0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        // hold the request; relative fire time fits in 63 bits
                        r_req      <= saq_pkg::t_req'(i_req_type);
                        r_id       <= i_alarm_id;
                        r_now      <= i_now;
                        r_fire     <= (i_req_type == saq_pkg::REQ_ARM_REL)
                                    ? FW'(i_now) + FW'(i_time_value) : FW'(i_time_value);
                        r_moved    <= 1'b0;
                        r_status   <= saq_pkg::ST_OK;
                        r_fired    <= 1'b0;
                        r_fired_id <= '0;
                        r_load     <= 1'b0;
                        r_value    <= '0;
                        r_state    <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (r_req == saq_pkg::REQ_EVENT) begin
                        if (r_head == NIL) begin
                            r_status <= saq_pkg::ST_EMPTY;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_EVT_HEAD;
                        end
                    end else if (!id_ok) begin
                        // slot out of range: drop the request
                        r_status <= (r_req == saq_pkg::REQ_CANCEL)
                                  ? saq_pkg::ST_NOT_ARMED : saq_pkg::ST_OK;
                        r_state  <= S_DONE;
                    end else if (r_armed[id_ix]) begin
                        // cancel, or rearm: unlink first
                        r_state <= S_UNL_SELF;
                    end else if (r_req == saq_pkg::REQ_CANCEL) begin
                        r_status <= saq_pkg::ST_NOT_ARMED;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_INS_INIT;
                    end
                end
                S_UNL_SELF: begin
                    r_nx           <= rd_next;
                    r_pv           <= rd_prev;
                    r_armed[id_ix] <= 1'b0;
                    if (rd_next == NIL) begin
                        r_tail <= rd_prev;
                    end
                    if (rd_prev == NIL) begin
                        r_head  <= rd_next;
                        r_moved <= (rd_next != NIL);
                    end
                    if (rd_next != NIL) begin
                        r_state <= S_UNL_NX;
                    end else if (rd_prev != NIL) begin
                        r_state <= S_UNL_PV;
                    end else begin
                        r_state <= S_UNL_END;
                    end
                end
                S_UNL_NX: begin
                    r_state <= (r_pv != NIL) ? S_UNL_PV : S_UNL_END;
                end
                S_UNL_PV: begin
                    r_state <= S_UNL_END;
                end
                S_UNL_END: begin
                    if (r_req == saq_pkg::REQ_CANCEL) begin
                        r_state <= r_moved ? S_RELOAD : S_DONE;
                    end else begin
                        r_state <= S_INS_INIT;
                    end
                end
                S_INS_INIT: begin
                    r_armed[id_ix] <= 1'b1;
                    r_cur          <= r_head;
                    r_state        <= (r_head == NIL) ? S_INS_TAIL : S_WALK;
                end
                S_WALK: begin
                    // advance one slot per cycle; equal fire times go after
                    r_ent <= ram_rdata[EW-1:LW];
                    if (rd_fire > r_fire) begin
                        r_pv    <= rd_prev;
                        r_state <= S_INS_CUR;
                    end else begin
                        r_cur <= rd_next;
                        if (rd_next == NIL) begin
                            r_state <= S_INS_TAIL;
                        end
                    end
                end
                S_INS_CUR: begin
                    if (r_pv != NIL) begin
                        r_state <= S_INS_PV;
                    end else begin
                        r_head  <= s_link;
                        r_moved <= 1'b1;
                        r_state <= S_INS_END;
                    end
                end
                S_INS_PV: begin
                    r_state <= S_INS_END;
                end
                S_INS_TAIL: begin
                    if (r_tail != NIL) begin
                        r_state <= S_INS_TAILN;
                    end else begin
                        r_head  <= s_link;
                        r_tail  <= s_link;
                        r_moved <= 1'b1;
                        r_state <= S_INS_END;
                    end
                end
                S_INS_TAILN: begin
                    r_tail  <= s_link;
                    r_state <= S_INS_END;
                end
                S_INS_END: begin
                    r_state <= r_moved ? S_RELOAD : S_DONE;
                end
                S_RELOAD: begin
                    r_load  <= 1'b1;
                    r_value <= reload_val;
                    r_state <= S_DONE;
                end
                S_EVT_HEAD: begin
                    if (FW'(r_now) < rd_fire) begin
                        // too early: rearm the decrementer for the same head
                        r_status <= saq_pkg::ST_EARLY;
                        r_load   <= 1'b1;
                        r_value  <= reload_val;
                        r_state  <= S_DONE;
                    end else begin
                        r_status                  <= saq_pkg::ST_FIRED;
                        r_fired                   <= 1'b1;
                        r_fired_id                <= 4'(r_head);
                        r_armed[r_head[IW-1:0]]   <= 1'b0;
                        r_head                    <= rd_next;
                        r_nx                      <= rd_next;
                        if (rd_next == NIL) begin
                            r_tail  <= NIL;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_EVT_NX;
                        end
                    end
                end
                S_EVT_NX: begin
                    r_load  <= 1'b1;
                    r_value <= reload_val;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    o_valid       <= 1'b1;
                    o_status      <= r_status;
                    o_fired       <= r_fired;
                    o_fired_id    <= r_fired_id;
                    o_timer_load  <= r_load;
                    o_timer_value <= r_value;
                    r_state       <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
